// File: sv/pblt_pkg.sv
// ----------------------------------------------------------------------------
// pblt_pkg
// Shared constants, log format and lse correction table for the log-tail unit.
// ----------------------------------------------------------------------------
package pblt_pkg;

  localparam int LOG_W                  = 28;
  localparam int MAX_TAIL_COUNT_DEF     = 64;
  localparam int LOG_FRAC_BITS_DEF      = 16;
  localparam int LSE_TABLE_SIZE         = 24;
  localparam logic signed [LOG_W-1:0] LOG_FLOOR = {1'b1, {(LOG_W-1){1'b0}}};
  localparam logic [29:0] LN2_Q30       = 30'd744261118;

  typedef logic signed [LOG_W-1:0] log_t;

  // ln(1 + exp(-x)) in Q16, x = (i + 0.5) / 2
  function automatic logic [15:0] lse_corr(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd37745;
      5'd1:    v = 16'd25354;
      5'd2:    v = 16'd16510;
      5'd3:    v = 16'd10500;
      5'd4:    v = 16'd6567;
      5'd5:    v = 16'd4061;
      5'd6:    v = 16'd2493;
      5'd7:    v = 16'd1523;
      5'd8:    v = 16'd928;
      5'd9:    v = 16'd565;
      5'd10:   v = 16'd343;
      5'd11:   v = 16'd208;
      5'd12:   v = 16'd126;
      5'd13:   v = 16'd77;
      5'd14:   v = 16'd47;
      5'd15:   v = 16'd28;
      5'd16:   v = 16'd17;
      5'd17:   v = 16'd10;
      5'd18:   v = 16'd6;
      5'd19:   v = 16'd4;
      5'd20:   v = 16'd2;
      5'd21:   v = 16'd1;
      5'd22:   v = 16'd1;
      5'd23:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/pblt_log.sv
// ----------------------------------------------------------------------------
// pblt_log
// Iterative ln(x / 65536): normalize, one square-and-compare per fraction bit,
// then scale by ln 2.
// ----------------------------------------------------------------------------
module pblt_log #(
  parameter int LOG_FRAC_BITS = pblt_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [16:0]         x,
  output logic                done,
  output pblt_pkg::log_t      result
);

  localparam int CW = $clog2(LOG_FRAC_BITS);
  localparam int NW = LOG_FRAC_BITS + 5;
  localparam int PW = NW + 30;

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_MUL, S_FIN} st_t;

  st_t                      state_r;
  logic [CW-1:0]            cnt_r;
  logic [30:0]              m_r;
  logic [LOG_FRAC_BITS-1:0] frac_r;
  logic [4:0]               e_r;
  logic                     zero_r;
  logic [PW-1:0]            prod_r;

  logic [4:0]  e_c;
  logic [47:0] norm;
  logic [61:0] sq;
  logic [31:0] t;
  logic [NW-1:0] neg;
  logic [PW:0] rnd;
  logic [31:0] mag;

  always_comb begin
    e_c = 5'd0;
    for (int i = 1; i < 17; i++) begin
      if (x[i]) e_c = 5'(i);
    end
    norm = 48'(x) << (5'd30 - e_c);
    sq   = 62'(m_r) * 62'(m_r);
    t    = sq[61:30];
    neg  = (NW'(5'd16 - e_r) << LOG_FRAC_BITS) - NW'(frac_r);
    rnd  = (PW+1)'(prod_r) + ((PW+1)'(1) << 29);
    mag  = 32'(rnd[PW:30]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            e_r     <= e_c;
            zero_r  <= (x == 17'd0);
            m_r     <= norm[30:0];
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (t[31]) begin
            m_r    <= t[31:1];
            frac_r <= {frac_r[LOG_FRAC_BITS-2:0], 1'b1};
          end else begin
            m_r    <= t[30:0];
            frac_r <= {frac_r[LOG_FRAC_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(LOG_FRAC_BITS - 1)) state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PW'(neg) * PW'(pblt_pkg::LN2_Q30);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (zero_r || mag > 32'd134217728) begin
            result <= pblt_pkg::LOG_FLOOR;
          end else begin
            result <= pblt_pkg::log_t'(-mag);
          end
          done    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/poisson_binomial_log_tail_unit.sv
// ----------------------------------------------------------------------------
// poisson_binomial_log_tail_unit
// Log-domain tail probability of a Poisson-binomial error count.
// ----------------------------------------------------------------------------
// Input beats carry one read position each: error probability (Q0.16), the
// tail count K and a last flag. in_stall is high while a beat is processed.
// Each beat first gets ln p and ln(1-p) from the two log units (in parallel,
// one fraction bit per cycle), then runs the row sweep: one read of the row
// memory per cycle, K-1 down to 0, with the lse update and write-back two
// stages behind. A new beat is taken only after the sweep has drained; a last
// beat first passes through the emit state, where its result is registered.
// On a beat with the last flag one result beat follows: the log tail (or the
// floor with tail_reached low if the read was shorter than K). The result sits
// in an output register; if out_stall holds it, the next beat is still taken
// and only the following result waits. Completing a read clears all row valid
// bits at once. Reset (rst_n low, synchronous) returns to the empty row.
// ----------------------------------------------------------------------------
module poisson_binomial_log_tail_unit #(
  parameter int MAX_TAIL_COUNT = pblt_pkg::MAX_TAIL_COUNT_DEF,
  parameter int LOG_FRAC_BITS  = pblt_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_error_prob,
  input  logic [6:0]           in_tail_count,
  input  logic                 in_last_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [27:0]   out_log_pvalue,
  output logic                 out_tail_reached
);

  localparam int AW    = $clog2(MAX_TAIL_COUNT);
  localparam int KW    = $clog2(MAX_TAIL_COUNT + 1);
  localparam int IW    = (KW > 7) ? KW : 7;
  localparam int SH_UP = (LOG_FRAC_BITS >= 16) ? LOG_FRAC_BITS - 16 : 0;
  localparam int SH_DN = (LOG_FRAC_BITS < 16) ? 16 - LOG_FRAC_BITS : 0;
  localparam int RND   = (LOG_FRAC_BITS < 16) ? (1 << (15 - LOG_FRAC_BITS)) : 0;
  localparam pblt_pkg::log_t FLOOR = pblt_pkg::LOG_FLOOR;

  typedef enum logic [2:0] {S_IDLE, S_LOG, S_SWEEP, S_DRAIN, S_EMIT} st_t;
  typedef enum logic [1:0] {OP_NONE, OP_TAIL, OP_ROW, OP_R0} op_t;

  function automatic pblt_pkg::log_t log_add(input pblt_pkg::log_t a,
                                             input pblt_pkg::log_t b);
    logic signed [28:0] s;
    s = 29'(a) + 29'(b);
    if (a == FLOOR || b == FLOOR || s < 29'(FLOOR)) return FLOOR;
    return s[27:0];
  endfunction

  function automatic pblt_pkg::log_t lse(input pblt_pkg::log_t a,
                                         input pblt_pkg::log_t b);
    pblt_pkg::log_t hi;
    pblt_pkg::log_t lo;
    logic [28:0] d;
    logic [28:0] idx;
    logic [31:0] corr;
    logic signed [33:0] s;
    if (a == FLOOR) return b;
    if (b == FLOOR) return a;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    d    = 29'(29'(hi) - 29'(lo));
    idx  = d >> (LOG_FRAC_BITS - 1);
    if (idx >= 29'(pblt_pkg::LSE_TABLE_SIZE)) return hi;
    corr = 32'(pblt_pkg::lse_corr(idx[4:0]));
    if (LOG_FRAC_BITS >= 16) corr = corr << SH_UP;
    else corr = (corr + 32'(RND)) >> SH_DN;
    s = 34'(hi) + $signed({2'b00, corr});
    if (s > 34'sd0) return '0;
    return s[27:0];
  endfunction

  st_t                 state_r;
  logic [KW-1:0]       kt_r;
  logic                last_r;
  logic [15:0]         pos_r;
  pblt_pkg::log_t      tail_r;
  logic                log_go_r;
  logic [16:0]         xp_r;
  logic [16:0]         xq_r;
  logic [AW-1:0]       rd_idx_r;
  logic [1:0]          drain_r;
  logic [MAX_TAIL_COUNT-1:0] vld_r;

  logic                dl_go_r;
  logic [AW-1:0]       dl_idx_r;
  logic                rd_vld_r;
  pblt_pkg::log_t      rd_data_r;
  pblt_pkg::log_t      prev_r;
  logic                r0_pend_r;

  op_t                 s2_op_r;
  logic [AW-1:0]       s2_idx_r;
  pblt_pkg::log_t      s2_a_r;
  pblt_pkg::log_t      s2_b_r;

  pblt_pkg::log_t      mem [MAX_TAIL_COUNT];

  logic                ln_done;
  logic                lnq_done;
  pblt_pkg::log_t      ln_p;
  pblt_pkg::log_t      ln_q;

  logic [IW-1:0]       k_in;
  logic [KW-1:0]       k_eff;
  logic                rd_en;
  logic                wr_en;
  pblt_pkg::log_t      wr_data;
  pblt_pkg::log_t      row_old;
  logic [AW-1:0]       k_top;

  pblt_log #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_p (
    .clk(clk), .rst_n(rst_n), .start(log_go_r), .x(xp_r),
    .done(ln_done), .result(ln_p)
  );

  pblt_log #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_q (
    .clk(clk), .rst_n(rst_n), .start(log_go_r), .x(xq_r),
    .done(lnq_done), .result(ln_q)
  );

  assign in_stall = (state_r != S_IDLE);
  assign k_top    = AW'(kt_r - 1'b1);
  assign rd_en    = (state_r == S_SWEEP);

  always_comb begin
    k_in = IW'(in_tail_count);
    if (k_in == '0) k_eff = KW'(1);
    else if (k_in > IW'(MAX_TAIL_COUNT)) k_eff = KW'(MAX_TAIL_COUNT);
    else k_eff = KW'(k_in);
    row_old = rd_vld_r ? rd_data_r : ((dl_idx_r == '0) ? '0 : FLOOR);
    wr_en   = (s2_op_r == OP_ROW) || (s2_op_r == OP_R0);
    wr_data = (s2_op_r == OP_ROW) ? lse(s2_a_r, s2_b_r) : s2_a_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[s2_idx_r] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      tail_r    <= FLOOR;
      vld_r     <= '0;
      log_go_r  <= 1'b0;
      dl_go_r   <= 1'b0;
      r0_pend_r <= 1'b0;
      s2_op_r   <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      log_go_r <= 1'b0;
      if (out_valid && !out_stall && state_r != S_EMIT) out_valid <= 1'b0;

      dl_go_r  <= rd_en;
      dl_idx_r <= rd_idx_r;
      if (rd_en) rd_vld_r <= vld_r[rd_idx_r];

      s2_op_r   <= OP_NONE;
      r0_pend_r <= 1'b0;
      if (dl_go_r) begin
        prev_r <= row_old;
        s2_a_r <= log_add(row_old, ln_p);
        s2_b_r <= log_add(prev_r, ln_q);
        s2_idx_r <= dl_idx_r + 1'b1;
        s2_op_r <= (dl_idx_r == k_top) ? OP_TAIL : OP_ROW;
        r0_pend_r <= (dl_idx_r == '0);
      end else if (r0_pend_r) begin
        s2_a_r   <= log_add(prev_r, ln_q);
        s2_idx_r <= '0;
        s2_op_r  <= OP_R0;
      end

      if (s2_op_r == OP_TAIL) tail_r <= lse(tail_r, s2_a_r);
      if (wr_en) vld_r[s2_idx_r] <= 1'b1;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kt_r     <= k_eff;
            last_r   <= in_last_item;
            xp_r     <= {1'b0, in_error_prob};
            xq_r     <= 17'h10000 - 17'(in_error_prob);
            log_go_r <= 1'b1;
            if (pos_r != 16'hFFFF) pos_r <= pos_r + 1'b1;
            state_r  <= S_LOG;
          end
        end
        S_LOG: begin
          if (ln_done && lnq_done) begin
            rd_idx_r <= k_top;
            state_r  <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (rd_idx_r == '0) begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r - 1'b1;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == 2'd2) state_r <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (pos_r >= 16'(kt_r)) begin
              out_log_pvalue   <= tail_r;
              out_tail_reached <= 1'b1;
            end else begin
              out_log_pvalue   <= FLOOR;
              out_tail_reached <= 1'b0;
            end
            pos_r   <= '0;
            tail_r  <= FLOOR;
            vld_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/pblt_checker.sv
// ----------------------------------------------------------------------------
// pblt_checker
// Port-level checks for the log-tail unit, bound to the top level.
// ----------------------------------------------------------------------------
module pblt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [27:0] out_log_pvalue,
  input logic               out_tail_reached
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken without going busy");

  a_short_read_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tail_reached |-> out_log_pvalue == pblt_pkg::LOG_FLOOR)
    else $error("short read must report floor");

  a_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_log_pvalue[27] || out_log_pvalue == 28'sd0))
    else $error("log probability above zero");

endmodule

bind poisson_binomial_log_tail_unit pblt_checker u_pblt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_log_pvalue(out_log_pvalue), .out_tail_reached(out_tail_reached)
);
